// File: rtl/core/qm_pkg.sv
// ============================================================================
// qm_pkg - shared definitions for the quaternion multiplier
// Default widths, lane sign masks and the stage enable bundle.
// ============================================================================
package qm_pkg;

    // Default component format, signed Q16.16
    localparam int COMP_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Width of every component port
    localparam int IO_WIDTH = 32;

    // Number of pipeline stages, including the output register
    localparam int NUM_STAGES = 6;

    // Per lane: bit i set means product term i is subtracted
    localparam logic [3:0] LANE_W_NEG = 4'b1110;  // w1w2 - x1x2 - y1y2 - z1z2
    localparam logic [3:0] LANE_V_NEG = 4'b0100;  // cross product term pair

    // Advance enables, one per pipeline stage ahead of the output register
    typedef struct packed {
        logic mul_a;   // partial products
        logic mul_b;   // full products
        logic sum1;    // pair sums
        logic sum2;    // lane sum
        logic fin;     // round and saturate
    } stage_en_t;

endpackage

// File: rtl/core/qm_mul.sv
// ============================================================================
// qm_mul - two-stage signed multiplier
// Splits each operand into halves, registers the four partial products,
// then combines them into the full signed product.
// ============================================================================
module qm_mul #(
    parameter int COMP_WIDTH = qm_pkg::COMP_WIDTH_DEF
) (
    input  logic                           clk,
    input  qm_pkg::stage_en_t              en,
    input  logic        [COMP_WIDTH-1:0]   a,
    input  logic        [COMP_WIDTH-1:0]   b,
    output logic signed [2*COMP_WIDTH-1:0] p
);

    localparam int H   = COMP_WIDTH / 2;
    localparam int HW  = COMP_WIDTH - H;
    localparam int PW  = 2 * COMP_WIDTH;
    localparam int HHW = 2 * HW;
    localparam int MW  = COMP_WIDTH + 1;
    localparam int LLW = 2 * H;

    logic signed [HW-1:0]       ah;
    logic signed [HW-1:0]       bh;
    logic signed [H:0]          al_s;
    logic signed [H:0]          bl_s;

    logic signed [2*HW-1:0]     hh_reg;
    logic signed [COMP_WIDTH:0] hl_reg;
    logic signed [COMP_WIDTH:0] lh_reg;
    logic        [2*H-1:0]      ll_reg;

    logic signed [PW-1:0]       hh_x;
    logic signed [PW-1:0]       hl_x;
    logic signed [PW-1:0]       lh_x;
    logic signed [PW-1:0]       ll_x;
    logic signed [PW-1:0]       p_next;
    logic signed [PW-1:0]       p_reg;

    assign ah   = $signed(a[COMP_WIDTH-1:H]);
    assign bh   = $signed(b[COMP_WIDTH-1:H]);
    assign al_s = $signed({1'b0, a[H-1:0]});
    assign bl_s = $signed({1'b0, b[H-1:0]});

    always_ff @(posedge clk)
    begin
        if (en.mul_a)
        begin
            hh_reg <= HHW'(ah) * HHW'(bh);
            hl_reg <= MW'(ah) * MW'(bl_s);
            lh_reg <= MW'(al_s) * MW'(bh);
            ll_reg <= LLW'(a[H-1:0]) * LLW'(b[H-1:0]);
        end
    end

    always_comb
    begin
        hh_x   = PW'(hh_reg);
        hl_x   = PW'(hl_reg);
        lh_x   = PW'(lh_reg);
        ll_x   = $signed({{(PW-2*H){1'b0}}, ll_reg});
        p_next = (hh_x <<< (2 * H)) + ((hl_x + lh_x) <<< H) + ll_x;
    end

    always_ff @(posedge clk)
    begin
        if (en.mul_b)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// File: rtl/core/qm_lane.sv
// ============================================================================
// qm_lane - one product component
// Four signed products, signed sum in two adder stages, then round to
// nearest (ties up) and saturate to the component range.
// ============================================================================
module qm_lane #(
    parameter int         COMP_WIDTH = qm_pkg::COMP_WIDTH_DEF,
    parameter int         FRAC_BITS  = qm_pkg::FRAC_BITS_DEF,
    parameter logic [3:0] NEG        = qm_pkg::LANE_W_NEG
) (
    input  logic                         clk,
    input  qm_pkg::stage_en_t            en,
    input  logic [3:0][COMP_WIDTH-1:0]   a,
    input  logic [3:0][COMP_WIDTH-1:0]   b,
    output logic       [COMP_WIDTH-1:0]  res,
    output logic                         sat
);

    localparam int PW    = 2 * COMP_WIDTH;
    localparam int SUM_W = PW + 2;

    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);
    localparam logic [COMP_WIDTH-1:0]   CMAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};
    localparam logic [COMP_WIDTH-1:0]   CMIN = {1'b1, {(COMP_WIDTH-1){1'b0}}};

    logic signed [PW-1:0]    p [4];
    logic signed [SUM_W-1:0] term [4];
    logic signed [SUM_W-1:0] t0_reg;
    logic signed [SUM_W-1:0] t1_reg;
    logic signed [SUM_W-1:0] s_reg;
    logic signed [SUM_W-1:0] rnd;
    logic signed [SUM_W-1:0] shv;
    logic                    ovf;
    logic [COMP_WIDTH-1:0]   res_next;
    logic [COMP_WIDTH-1:0]   res_reg;
    logic                    sat_reg;

    for (genvar i = 0; i < 4; i++)
    begin : g_mul
        qm_mul #(
            .COMP_WIDTH (COMP_WIDTH)
        ) u_mul (
            .clk (clk),
            .en  (en),
            .a   (a[i]),
            .b   (b[i]),
            .p   (p[i])
        );

        always_comb
        begin
            term[i] = SUM_W'(p[i]);
            if (NEG[i])
            begin
                term[i] = -term[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.sum1)
        begin
            t0_reg <= term[0] + term[1];
            t1_reg <= term[2] + term[3];
        end
        if (en.sum2)
        begin
            s_reg <= t0_reg + t1_reg;
        end
    end

    // Overflow when the bits above the component sign are not all copies of it
    always_comb
    begin
        rnd = s_reg + HALF;
        shv = rnd >>> FRAC_BITS;
        ovf = !((&shv[SUM_W-1:COMP_WIDTH-1]) || !(|shv[SUM_W-1:COMP_WIDTH-1]));
        if (!ovf)
        begin
            res_next = shv[COMP_WIDTH-1:0];
        end
        else if (shv[SUM_W-1])
        begin
            res_next = CMIN;
        end
        else
        begin
            res_next = CMAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.fin)
        begin
            res_reg <= res_next;
            sat_reg <= ovf;
        end
    end

    assign res = res_reg;
    assign sat = sat_reg;

endmodule

// File: rtl/core/quaternion_multiply.sv
// ============================================================================
// quaternion_multiply - fixed-point quaternion product
// Unnormalized product of two quaternions in the subtracted-cross-product
// sign convention, with rounding, saturation and a saturation flag.
// ============================================================================
// Each item carries q1 and q2 as (x, y, z, w), vector part first, in signed
// fixed point with FRAC_BITS fraction bits in COMP_WIDTH-bit components
// (Q16.16 by default). The result is
//     w = w1*w2 - (v1 . v2)
//     v = w1*v2 + w2*v1 - (v1 x v2)
// summed exactly at full product precision, rounded to nearest with ties
// toward plus infinity, and saturated; saturated is set if any of the four
// components clipped. Inputs are read as their low COMP_WIDTH bits,
// sign-extended (a wider component zero-extends the 32-bit port); results
// are the low 32 bits of the sign-extended component.
// Rate: one item per cycle sustained unless the output stalls. An item passes
// six register stages: two in the split multipliers, two in the adder tree,
// one in round/saturate, one in the output merge. Four lanes (w, x, y, z) each
// own four multipliers, sixteen in all, which is what sets the rate. Every stage
// advances on its own, so bubbles close up and items keep entering while a
// finished result waits for out_ready; in_ready drops only when all six stages
// hold items and the output is stalled.
// ============================================================================
module quaternion_multiply #(
    parameter int COMP_WIDTH = qm_pkg::COMP_WIDTH_DEF,
    parameter int FRAC_BITS  = qm_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [qm_pkg::IO_WIDTH-1:0]   q1_x,
    input  logic [qm_pkg::IO_WIDTH-1:0]   q1_y,
    input  logic [qm_pkg::IO_WIDTH-1:0]   q1_z,
    input  logic [qm_pkg::IO_WIDTH-1:0]   q1_w,
    input  logic [qm_pkg::IO_WIDTH-1:0]   q2_x,
    input  logic [qm_pkg::IO_WIDTH-1:0]   q2_y,
    input  logic [qm_pkg::IO_WIDTH-1:0]   q2_z,
    input  logic [qm_pkg::IO_WIDTH-1:0]   q2_w,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [qm_pkg::IO_WIDTH-1:0]   prod_x,
    output logic [qm_pkg::IO_WIDTH-1:0]   prod_y,
    output logic [qm_pkg::IO_WIDTH-1:0]   prod_z,
    output logic [qm_pkg::IO_WIDTH-1:0]   prod_w,
    output logic                          saturated
);

    localparam int IOW = qm_pkg::IO_WIDTH;
    localparam int NS  = qm_pkg::NUM_STAGES;

    // Operand order: x1 y1 z1 w1 x2 y2 z2 w2
    localparam int X1 = 0;
    localparam int Y1 = 1;
    localparam int Z1 = 2;
    localparam int W1 = 3;
    localparam int X2 = 4;
    localparam int Y2 = 5;
    localparam int Z2 = 6;
    localparam int W2 = 7;

    logic [IOW-1:0]             in_arr [8];
    logic [COMP_WIDTH-1:0]      op     [8];

    logic [NS-1:0]              valid_reg;
    logic [NS-1:0]              valid_next;
    logic [NS-1:0]              adv;
    qm_pkg::stage_en_t          en;

    logic [3:0][COMP_WIDTH-1:0] a_w, b_w, a_x, b_x, a_y, b_y, a_z, b_z;
    logic [COMP_WIDTH-1:0]      res_w, res_x, res_y, res_z;
    logic                       sat_w, sat_x, sat_y, sat_z;

    logic [IOW-1:0]             px_next, py_next, pz_next, pw_next;
    logic [IOW-1:0]             prod_x_reg, prod_y_reg, prod_z_reg, prod_w_reg;
    logic                       sat_reg;

    assign in_arr[X1] = q1_x;
    assign in_arr[Y1] = q1_y;
    assign in_arr[Z1] = q1_z;
    assign in_arr[W1] = q1_w;
    assign in_arr[X2] = q2_x;
    assign in_arr[Y2] = q2_y;
    assign in_arr[Z2] = q2_z;
    assign in_arr[W2] = q2_w;

    // Component format: low bits sign-extended, or the port zero-extended
    for (genvar i = 0; i < 8; i++)
    begin : g_op
        if (COMP_WIDTH <= IOW)
        begin : g_narrow
            assign op[i] = in_arr[i][COMP_WIDTH-1:0];
        end
        else
        begin : g_wide
            assign op[i] = {{(COMP_WIDTH-IOW){1'b0}}, in_arr[i]};
        end
    end

    // ------------------------------------------------------------------
    // Stage control: a stage advances when empty or when the next one does
    // ------------------------------------------------------------------
    always_comb
    begin
        adv[NS-1] = !valid_reg[NS-1] || out_ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end

        valid_next = valid_reg;
        if (adv[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int i = 1; i < NS; i++)
        begin
            if (adv[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign en.mul_a = adv[0];
    assign en.mul_b = adv[1];
    assign en.sum1  = adv[2];
    assign en.sum2  = adv[3];
    assign en.fin   = adv[4];

    assign in_ready = adv[0];

    // ------------------------------------------------------------------
    // Lane operands
    // ------------------------------------------------------------------
    // w: w1w2, x1x2, y1y2, z1z2
    assign a_w[0] = op[W1];  assign b_w[0] = op[W2];
    assign a_w[1] = op[X1];  assign b_w[1] = op[X2];
    assign a_w[2] = op[Y1];  assign b_w[2] = op[Y2];
    assign a_w[3] = op[Z1];  assign b_w[3] = op[Z2];
    // x: w1x2, w2x1, y1z2, y2z1
    assign a_x[0] = op[W1];  assign b_x[0] = op[X2];
    assign a_x[1] = op[W2];  assign b_x[1] = op[X1];
    assign a_x[2] = op[Y1];  assign b_x[2] = op[Z2];
    assign a_x[3] = op[Y2];  assign b_x[3] = op[Z1];
    // y: w1y2, w2y1, z1x2, z2x1
    assign a_y[0] = op[W1];  assign b_y[0] = op[Y2];
    assign a_y[1] = op[W2];  assign b_y[1] = op[Y1];
    assign a_y[2] = op[Z1];  assign b_y[2] = op[X2];
    assign a_y[3] = op[Z2];  assign b_y[3] = op[X1];
    // z: w1z2, w2z1, x1y2, x2y1
    assign a_z[0] = op[W1];  assign b_z[0] = op[Z2];
    assign a_z[1] = op[W2];  assign b_z[1] = op[Z1];
    assign a_z[2] = op[X1];  assign b_z[2] = op[Y2];
    assign a_z[3] = op[X2];  assign b_z[3] = op[Y1];

    qm_lane #(
        .COMP_WIDTH (COMP_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .NEG        (qm_pkg::LANE_W_NEG)
    ) u_lane_w (
        .clk (clk), .en (en), .a (a_w), .b (b_w), .res (res_w), .sat (sat_w)
    );

    qm_lane #(
        .COMP_WIDTH (COMP_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .NEG        (qm_pkg::LANE_V_NEG)
    ) u_lane_x (
        .clk (clk), .en (en), .a (a_x), .b (b_x), .res (res_x), .sat (sat_x)
    );

    qm_lane #(
        .COMP_WIDTH (COMP_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .NEG        (qm_pkg::LANE_V_NEG)
    ) u_lane_y (
        .clk (clk), .en (en), .a (a_y), .b (b_y), .res (res_y), .sat (sat_y)
    );

    qm_lane #(
        .COMP_WIDTH (COMP_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .NEG        (qm_pkg::LANE_V_NEG)
    ) u_lane_z (
        .clk (clk), .en (en), .a (a_z), .b (b_z), .res (res_z), .sat (sat_z)
    );

    // ------------------------------------------------------------------
    // Merge: port format and combined saturation flag
    // ------------------------------------------------------------------
    if (COMP_WIDTH >= IOW)
    begin : g_out_trunc
        assign px_next = res_x[IOW-1:0];
        assign py_next = res_y[IOW-1:0];
        assign pz_next = res_z[IOW-1:0];
        assign pw_next = res_w[IOW-1:0];
    end
    else
    begin : g_out_sext
        assign px_next = {{(IOW-COMP_WIDTH){res_x[COMP_WIDTH-1]}}, res_x};
        assign py_next = {{(IOW-COMP_WIDTH){res_y[COMP_WIDTH-1]}}, res_y};
        assign pz_next = {{(IOW-COMP_WIDTH){res_z[COMP_WIDTH-1]}}, res_z};
        assign pw_next = {{(IOW-COMP_WIDTH){res_w[COMP_WIDTH-1]}}, res_w};
    end

    always_ff @(posedge clk)
    begin
        if (adv[NS-1])
        begin
            prod_x_reg <= px_next;
            prod_y_reg <= py_next;
            prod_z_reg <= pz_next;
            prod_w_reg <= pw_next;
            sat_reg    <= sat_w | sat_x | sat_y | sat_z;
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign prod_x    = prod_x_reg;
    assign prod_y    = prod_y_reg;
    assign prod_z    = prod_z_reg;
    assign prod_w    = prod_w_reg;
    assign saturated = sat_reg;

endmodule

// File: rtl/core/qm_checker.sv
// ============================================================================
// qm_checker - port-level checks for quaternion_multiply
// Tracks items in flight and checks output behavior seen at the ports.
// ============================================================================
module qm_checker #(
    parameter int COMP_WIDTH = qm_pkg::COMP_WIDTH_DEF
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [qm_pkg::IO_WIDTH-1:0] prod_x,
    input logic [qm_pkg::IO_WIDTH-1:0] prod_y,
    input logic [qm_pkg::IO_WIDTH-1:0] prod_z,
    input logic [qm_pkg::IO_WIDTH-1:0] prod_w,
    input logic                        saturated
);

    localparam int IOW = qm_pkg::IO_WIDTH;
    localparam int CW  = $clog2(qm_pkg::NUM_STAGES + 2);

    // Clipped values as they appear on the ports
    localparam logic [IOW-1:0] SAT_MAX = (COMP_WIDTH > IOW) ? {IOW{1'b1}} :
        IOW'((64'd1 << (COMP_WIDTH - 1)) - 64'd1);
    localparam logic [IOW-1:0] SAT_MIN = (COMP_WIDTH > IOW) ? {IOW{1'b0}} : ~SAT_MAX;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          in_acc;
    logic          out_acc;
    logic          any_clip;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (in_acc && !out_acc)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!in_acc && out_acc)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign any_clip = prod_x == SAT_MAX || prod_x == SAT_MIN ||
                      prod_y == SAT_MAX || prod_y == SAT_MIN ||
                      prod_z == SAT_MAX || prod_z == SAT_MIN ||
                      prod_w == SAT_MAX || prod_w == SAT_MIN;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(prod_x) && $stable(prod_y)
            && $stable(prod_z) && $stable(prod_w) && $stable(saturated))
        else $error("stalled result changed");

    // No result without an item in flight
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count_reg != '0)
        else $error("result with no item in flight");

    // Pipeline never holds more items than it has stages
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(qm_pkg::NUM_STAGES))
        else $error("more items in flight than stages");

    // An empty output stage always lets an item in
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // Saturation shows as a clipped component
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> any_clip)
        else $error("saturation flag without a clipped component");

endmodule

bind quaternion_multiply qm_checker #(.COMP_WIDTH(COMP_WIDTH)) u_qm_checker (.*);

// File: dv/quaternion_multiply_test.sv
`timescale 1ns / 100ps
// ============================================================================
// quaternion_multiply_test - self-checking bench for the quaternion product
// A queue-fed driver offers quaternion pairs and a clocked monitor checks each
// product, field by field, against an in-bench fixed-point predictor.
// ============================================================================
// Flow:
//   - A short directed list covers identities, basis products, the range
//     extremes, exact limits, rounding ties on both signs and saturation
//     of every lane.
//   - It is followed by random pairs in phases. First no idling, then sender
//     gaps, then receiver stalls, then both. After the first phase there is a
//     burst in which the receiver holds off for a long stretch. During that
//     burst the sender keeps offering, so the six-stage pipe fills up and
//     in_ready drops.
// The block is an in-order pipeline. Every accepted pair yields exactly
// one product, so the expected queue stays in step with the output.
// ============================================================================
module quaternion_multiply_test;

    localparam int CW     = qm_pkg::COMP_WIDTH_DEF;
    localparam int FB     = qm_pkg::FRAC_BITS_DEF;
    localparam int IOW    = qm_pkg::IO_WIDTH;
    localparam int ACC_W  = 2 * CW + 4;     // four full products plus growth
    localparam int HALF_PERIOD = 2;
    localparam int HOLD_LEN    = 40;        // long receiver hold-off, cycles
    localparam int PHASE_ITEMS = 150;
    localparam int BURST_ITEMS = 40;
    localparam int MAX_REPORTS = 10;

    localparam logic [IOW-1:0] C_MAX  = 32'h7FFF_FFFF;
    localparam logic [IOW-1:0] C_MIN  = 32'h8000_0000;
    localparam logic [IOW-1:0] C_ONE  = 32'h0001_0000;   // +1.0
    localparam logic [IOW-1:0] C_MONE = 32'hFFFF_0000;   // -1.0
    localparam logic [IOW-1:0] C_ZERO = 32'h0000_0000;

    typedef logic signed [ACC_W-1:0] acc_t;

    typedef struct packed {
        logic [IOW-1:0] x;
        logic [IOW-1:0] y;
        logic [IOW-1:0] z;
        logic [IOW-1:0] w;
    } quat_t;

    typedef struct packed {
        quat_t a;
        quat_t b;
    } quat_pair_t;

    typedef struct packed {
        logic [IOW-1:0] x;
        logic [IOW-1:0] y;
        logic [IOW-1:0] z;
        logic [IOW-1:0] w;
        logic           sat;
    } quat_prod_t;

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    logic           in_ready;
    logic [IOW-1:0] q1_x      = '0;
    logic [IOW-1:0] q1_y      = '0;
    logic [IOW-1:0] q1_z      = '0;
    logic [IOW-1:0] q1_w      = '0;
    logic [IOW-1:0] q2_x      = '0;
    logic [IOW-1:0] q2_y      = '0;
    logic [IOW-1:0] q2_z      = '0;
    logic [IOW-1:0] q2_w      = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    logic [IOW-1:0] prod_x;
    logic [IOW-1:0] prod_y;
    logic [IOW-1:0] prod_z;
    logic [IOW-1:0] prod_w;
    logic           saturated;

    quaternion_multiply u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .q1_x      (q1_x),
        .q1_y      (q1_y),
        .q1_z      (q1_z),
        .q1_w      (q1_w),
        .q2_x      (q2_x),
        .q2_y      (q2_y),
        .q2_z      (q2_z),
        .q2_w      (q2_w),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .prod_x    (prod_x),
        .prod_y    (prod_y),
        .prod_z    (prod_z),
        .prod_w    (prod_w),
        .saturated (saturated)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    quat_pair_t pending_pairs[$];       // items not yet offered
    quat_prod_t expected_products[$];   // products owed by the DUT, oldest first
    int         send_idle_pct  = 0;     // chance per free slot of a gap
    int         recv_stall_pct = 0;     // chance per cycle of out_ready low
    int         holds_asked    = 0;     // bumped to request a long hold-off
    int         holds_done     = 0;
    int         hold_left      = 0;
    int         mismatches     = 0;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    // Port value -> low CW bits, sign-extended into the accumulator width.
    function automatic acc_t widen(logic [IOW-1:0] v);
        logic signed [CW-1:0] c;
        c = CW'(v);
        return acc_t'(c);
    endfunction

    // Round half up, drop FB fraction bits, clip to the CW-bit range.
    // Bit IOW of the return value flags a clip.
    function automatic logic [IOW:0] round_clip(acc_t s);
        acc_t r;
        acc_t top;
        acc_t bottom;
        top    = (acc_t'(1) <<< (CW - 1)) - acc_t'(1);
        bottom = -(acc_t'(1) <<< (CW - 1));
        r      = (s + (acc_t'(1) <<< (FB - 1))) >>> FB;
        if (r > top)
            return {1'b1, top[IOW-1:0]};
        if (r < bottom)
            return {1'b1, bottom[IOW-1:0]};
        return {1'b0, r[IOW-1:0]};
    endfunction

    // w = w1w2 - v1.v2 ; v = w1 v2 + w2 v1 - v1 x v2
    function automatic quat_prod_t quat_product(quat_pair_t p);
        acc_t           x1, y1, z1, w1, x2, y2, z2, w2;
        acc_t           sx, sy, sz, sw;
        logic [IOW:0]   rx, ry, rz, rw;
        quat_prod_t     r;
        x1 = widen(p.a.x);
        y1 = widen(p.a.y);
        z1 = widen(p.a.z);
        w1 = widen(p.a.w);
        x2 = widen(p.b.x);
        y2 = widen(p.b.y);
        z2 = widen(p.b.z);
        w2 = widen(p.b.w);
        sw = w1 * w2 - x1 * x2 - y1 * y2 - z1 * z2;
        sx = w1 * x2 + w2 * x1 - (y1 * z2 - y2 * z1);
        sy = w1 * y2 + w2 * y1 - (z1 * x2 - z2 * x1);
        sz = w1 * z2 + w2 * z1 - (x1 * y2 - x2 * y1);
        rx = round_clip(sx);
        ry = round_clip(sy);
        rz = round_clip(sz);
        rw = round_clip(sw);
        r.x   = rx[IOW-1:0];
        r.y   = ry[IOW-1:0];
        r.z   = rz[IOW-1:0];
        r.w   = rw[IOW-1:0];
        r.sat = rx[IOW] | ry[IOW] | rz[IOW] | rw[IOW];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic quat_t quat(logic [IOW-1:0] x, logic [IOW-1:0] y,
                                   logic [IOW-1:0] z, logic [IOW-1:0] w);
        quat_t q;
        q.x = x;
        q.y = y;
        q.z = z;
        q.w = w;
        return q;
    endfunction

    task automatic push_pair(quat_t a, quat_t b);
        quat_pair_t p;
        p.a = a;
        p.b = b;
        pending_pairs.push_back(p);
    endtask

    // Mostly modest magnitudes so most products stay in range; a share of
    // full-width values and the range ends keep the clipping paths busy.
    function automatic logic [IOW-1:0] rand_comp();
        int                   pick;
        int                   nbits;
        logic signed [IOW-1:0] t;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return C_MAX;
        if (pick < 10)
            return C_MIN;
        if (pick < 14)
            return C_ZERO;
        if (pick < 18)
            return ($urandom_range(0, 1) != 0) ? C_ONE : C_MONE;
        if (pick < 40)
            return $urandom;
        nbits = $urandom_range(1, IOW);
        t = $urandom;
        t = (t <<< (IOW - nbits)) >>> (IOW - nbits);
        return t;
    endfunction

    function automatic quat_t rand_quat();
        return quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
    endfunction

    task automatic push_random(int count);
        for (int i = 0; i < count; i++)
            push_pair(rand_quat(), rand_quat());
    endtask

    // Wait until every queued item went in and every product came back.
    task automatic drain();
        while (pending_pairs.size() != 0 || in_valid || expected_products.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers the next pair whenever the input slot is free
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        quat_pair_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            // Item on the port accepted at this edge: its product is owed
            if (in_valid && in_ready)
                expected_products.push_back(quat_product(
                    {q1_x, q1_y, q1_z, q1_w, q2_x, q2_y, q2_z, q2_w}));
            if (!in_valid || in_ready)
            begin
                if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt = pending_pairs.pop_front();
                    in_valid <= 1'b1;
                    q1_x <= nxt.a.x;
                    q1_y <= nxt.a.y;
                    q1_z <= nxt.a.z;
                    q1_w <= nxt.a.w;
                    q2_x <= nxt.b.x;
                    q2_y <= nxt.b.y;
                    q2_z <= nxt.b.z;
                    q2_w <= nxt.b.w;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            hold_left  <= 0;
            holds_done <= 0;
        end
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (holds_done != holds_asked)
        begin
            out_ready  <= 1'b0;
            hold_left  <= HOLD_LEN - 1;
            holds_done <= holds_done + 1;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each product with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        quat_prod_t exp_p;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_products.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < MAX_REPORTS)
                    $display("%0t: unexpected product x=%h y=%h z=%h w=%h sat=%b",
                             $realtime, prod_x, prod_y, prod_z, prod_w, saturated);
            end
            else
            begin
                exp_p = expected_products.pop_front();
                if (prod_x !== exp_p.x || prod_y !== exp_p.y || prod_z !== exp_p.z ||
                    prod_w !== exp_p.w || saturated !== exp_p.sat)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < MAX_REPORTS)
                    begin
                        $display("%0t: product mismatch", $realtime);
                        $display("  expected x=%h y=%h z=%h w=%h sat=%b",
                                 exp_p.x, exp_p.y, exp_p.z, exp_p.w, exp_p.sat);
                        $display("  actual   x=%h y=%h z=%h w=%h sat=%b",
                                 prod_x, prod_y, prod_z, prod_w, saturated);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: identities and basis products
        push_pair(quat(C_ZERO, C_ZERO, C_ZERO, C_ZERO), quat(C_ZERO, C_ZERO, C_ZERO, C_ZERO));
        push_pair(quat(C_ZERO, C_ZERO, C_ZERO, C_ONE), quat(C_ZERO, C_ZERO, C_ZERO, C_ONE));
        push_pair(quat(C_ONE, C_ZERO, C_ZERO, C_ZERO), quat(C_ZERO, C_ONE, C_ZERO, C_ZERO));
        push_pair(quat(C_ZERO, C_ONE, C_ZERO, C_ZERO), quat(C_ZERO, C_ZERO, C_ONE, C_ZERO));
        push_pair(quat(C_ZERO, C_ZERO, C_ONE, C_ZERO), quat(C_ONE, C_ZERO, C_ZERO, C_ZERO));
        push_pair(quat(C_ONE, C_ZERO, C_ZERO, C_ZERO), quat(C_ONE, C_ZERO, C_ZERO, C_ZERO));
        // Range ends everywhere
        push_pair(quat(C_MAX, C_MAX, C_MAX, C_MAX), quat(C_MAX, C_MAX, C_MAX, C_MAX));
        push_pair(quat(C_MIN, C_MIN, C_MIN, C_MIN), quat(C_MIN, C_MIN, C_MIN, C_MIN));
        push_pair(quat(C_MAX, C_MIN, C_MAX, C_MIN), quat(C_MIN, C_MAX, C_MIN, C_MAX));
        // Landing exactly on the limits, and one step past the top
        push_pair(quat(C_ZERO, C_ZERO, C_ZERO, C_MAX), quat(C_ZERO, C_ZERO, C_ZERO, C_ONE));
        push_pair(quat(C_ZERO, C_ZERO, C_ZERO, C_MIN), quat(C_ZERO, C_ZERO, C_ZERO, C_ONE));
        push_pair(quat(C_ZERO, C_ZERO, C_ZERO, C_MIN), quat(C_ZERO, C_ZERO, C_ZERO, C_MONE));
        // Rounding: exact half ties both signs, and just either side
        push_pair(quat(C_ZERO, C_ZERO, C_ZERO, 32'h1), quat(C_ZERO, C_ZERO, C_ZERO, 32'h8000));
        push_pair(quat(C_ZERO, C_ZERO, C_ZERO, 32'hFFFF_FFFF),
                  quat(C_ZERO, C_ZERO, C_ZERO, 32'h8000));
        push_pair(quat(C_ZERO, C_ZERO, C_ZERO, 32'h1), quat(C_ZERO, C_ZERO, C_ZERO, 32'h7FFF));
        push_pair(quat(C_ZERO, C_ZERO, C_ZERO, 32'hFFFF_FFFF),
                  quat(C_ZERO, C_ZERO, C_ZERO, 32'h7FFF));
        push_pair(quat(C_ZERO, C_ZERO, C_ZERO, 32'hFFFF_FFFF),
                  quat(C_ZERO, C_ZERO, C_ZERO, 32'h8001));
        // Per-lane clipping, positive and negative
        push_pair(quat(C_MAX, C_MAX, C_MAX, C_ZERO), quat(C_ZERO, C_ZERO, C_ZERO, C_MAX));
        push_pair(quat(C_MIN, C_MIN, C_MIN, C_ZERO), quat(C_ZERO, C_ZERO, C_ZERO, C_MAX));
        push_pair(quat(C_ZERO, C_MAX, C_ZERO, C_ZERO), quat(C_ZERO, C_ZERO, C_MAX, C_ZERO));
        push_pair(quat(C_ZERO, C_ZERO, C_MAX, C_ZERO), quat(C_ZERO, C_MAX, C_ZERO, C_ZERO));
        push_pair(quat(C_MAX, C_ZERO, C_ZERO, C_ZERO), quat(C_MAX, C_ZERO, C_ZERO, C_ZERO));
        drain();

        // Random phases: free flow, sender gaps, receiver stalls, both
        send_idle_pct  <= 0;
        recv_stall_pct <= 0;
        push_random(PHASE_ITEMS);
        drain();

        // Long hold-off while the sender keeps pushing: pipe fills, in_ready drops
        holds_asked <= holds_asked + 1;
        push_random(BURST_ITEMS);
        drain();

        send_idle_pct  <= 48;
        recv_stall_pct <= 0;
        push_random(PHASE_ITEMS);
        drain();

        send_idle_pct  <= 0;
        recv_stall_pct <= 48;
        push_random(PHASE_ITEMS);
        drain();

        send_idle_pct  <= 31;
        recv_stall_pct <= 31;
        push_random(PHASE_ITEMS);
        drain();

        // Let any stray output show up before judging
        repeat (4 * qm_pkg::NUM_STAGES) @(posedge clk);
        if (mismatches == 0 && expected_products.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog
    initial
    begin
        #400000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
